// ===== rtl/bbtc_pkg.sv =====
// ---------------------------------------------------------------------------
// bbtc_pkg
// Shared types, constants and helpers of the bounding box tile cutter.
// ---------------------------------------------------------------------------
package bbtc_pkg;

  localparam int MaxDims    = 4;
  localparam int CoordPorts = 4;
  localparam int NumLanes   = (MaxDims < CoordPorts) ? MaxDims : CoordPorts;

  localparam int CoordW   = 64;
  localparam int CountW   = 32;
  localparam int BytesW   = 33;
  localparam int DimsW    = 3;
  localparam int LimitW   = 32;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 32;

  localparam logic signed [CoordW-1:0] CoordMax = {1'b0, {(CoordW-1){1'b1}}};
  localparam logic signed [CoordW-1:0] CoordMin = {1'b1, {(CoordW-1){1'b0}}};

  localparam logic [DimsW-1:0]  NumDimsReset   = 3'd2;
  localparam logic [LimitW-1:0] TileLimitReset = 32'd4096;

  typedef enum logic [CfgIdxW-1:0] {
    CfgNumDims   = 2'd0,
    CfgTileLimit = 2'd1
  } cfg_idx_e;

  // per-lane control from the tile controller
  typedef struct packed {
    logic update;
    logic clear;
  } lane_ctrl_t;

  // what the tile controller decided for the current request
  typedef struct packed {
    logic emit;
    logic clear;
  } tile_event_t;

  // effective dimension count: zero counts as one, saturate at the lane count
  function automatic logic [DimsW-1:0] eff_dims(input logic [DimsW-1:0] n);
    logic [DimsW-1:0] r;
    r = n;
    if (n == '0) begin
      r = DimsW'(1);
    end else if (n > DimsW'(NumLanes)) begin
      r = DimsW'(NumLanes);
    end
    return r;
  endfunction

endpackage

// ===== rtl/bounding_box_tile_cutter.sv =====
// ---------------------------------------------------------------------------
// bounding_box_tile_cutter
// Cuts a point stream into fixed-size tiles and reports each tile's box.
// ---------------------------------------------------------------------------
// output: a tile result is registered and is in the output register in the cycle
//   after the request that closes it is accepted
// throughput: one request per cycle unless stalled, set by the min/max compare
//   in each lane and the byte counter compare that feed back into the state
// reset: box cleared, byte and tile counts zero, num_dims = 2,
//   tile_limit_bytes = 4096, output register empty
module bounding_box_tile_cutter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bbtc_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [bbtc_pkg::CfgDataW-1:0]       cfg_data_i,
  // point stream
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                func_i,
  input  logic signed [bbtc_pkg::CoordW-1:0]  coord_a_i,
  input  logic signed [bbtc_pkg::CoordW-1:0]  coord_b_i,
  input  logic signed [bbtc_pkg::CoordW-1:0]  coord_c_i,
  input  logic signed [bbtc_pkg::CoordW-1:0]  coord_d_i,
  // tile results
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [bbtc_pkg::CountW-1:0]         tile_number_o,
  output logic signed [bbtc_pkg::CoordW-1:0]  low_a_o,
  output logic signed [bbtc_pkg::CoordW-1:0]  low_b_o,
  output logic signed [bbtc_pkg::CoordW-1:0]  low_c_o,
  output logic signed [bbtc_pkg::CoordW-1:0]  low_d_o,
  output logic signed [bbtc_pkg::CoordW-1:0]  high_a_o,
  output logic signed [bbtc_pkg::CoordW-1:0]  high_b_o,
  output logic signed [bbtc_pkg::CoordW-1:0]  high_c_o,
  output logic signed [bbtc_pkg::CoordW-1:0]  high_d_o
);

  localparam int NL = bbtc_pkg::NumLanes;

  logic [bbtc_pkg::DimsW-1:0]  num_dims_q;
  logic [bbtc_pkg::LimitW-1:0] limit_q;
  logic [bbtc_pkg::DimsW-1:0]  dims;
  logic                        accept;

  logic signed [bbtc_pkg::CoordW-1:0] coord   [bbtc_pkg::CoordPorts];
  logic signed [bbtc_pkg::CoordW-1:0] lane_lo [NL];
  logic signed [bbtc_pkg::CoordW-1:0] lane_hi [NL];
  logic signed [bbtc_pkg::CoordW-1:0] low_q   [bbtc_pkg::CoordPorts];
  logic signed [bbtc_pkg::CoordW-1:0] high_q  [bbtc_pkg::CoordPorts];
  logic signed [bbtc_pkg::CoordW-1:0] low_d   [bbtc_pkg::CoordPorts];
  logic signed [bbtc_pkg::CoordW-1:0] high_d  [bbtc_pkg::CoordPorts];

  bbtc_pkg::tile_event_t       tile_ev;
  logic [bbtc_pkg::CountW-1:0] tile_number;
  logic [bbtc_pkg::CountW-1:0] tile_q;
  logic                        out_valid_q, out_valid_d;

  // configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_dims_q <= bbtc_pkg::NumDimsReset;
      limit_q    <= bbtc_pkg::TileLimitReset;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index_i == bbtc_pkg::CfgNumDims) begin
        num_dims_q <= cfg_data_i[bbtc_pkg::DimsW-1:0];
      end else if (cfg_index_i == bbtc_pkg::CfgTileLimit) begin
        limit_q <= cfg_data_i[bbtc_pkg::LimitW-1:0];
      end
    end
  end

  assign dims = bbtc_pkg::eff_dims(num_dims_q);

  // the output register frees up in the same cycle it is taken
  assign in_stall = out_valid_q && out_stall;
  assign accept   = in_valid && !in_stall;

  assign coord[0] = coord_a_i;
  assign coord[1] = coord_b_i;
  assign coord[2] = coord_c_i;
  assign coord[3] = coord_d_i;

  bbtc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .func_i        (func_i),
    .dims_i        (dims),
    .limit_i       (limit_q),
    .event_o       (tile_ev),
    .tile_number_o (tile_number)
  );

  for (genvar i = 0; i < NL; i++) begin : g_lane
    bbtc_pkg::lane_ctrl_t lane_ctrl;

    assign lane_ctrl.update = accept && !func_i && (bbtc_pkg::DimsW'(i) < dims);
    assign lane_ctrl.clear  = tile_ev.clear;

    bbtc_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (lane_ctrl),
      .coord_i (coord[i]),
      .low_o   (lane_lo[i]),
      .high_o  (lane_hi[i])
    );
  end

  // merge: unused dimensions read zero
  for (genvar i = 0; i < bbtc_pkg::CoordPorts; i++) begin : g_merge
    if (i < NL) begin : g_used
      assign low_d[i]  = (bbtc_pkg::DimsW'(i) < dims) ? lane_lo[i] : '0;
      assign high_d[i] = (bbtc_pkg::DimsW'(i) < dims) ? lane_hi[i] : '0;
    end else begin : g_none
      assign low_d[i]  = '0;
      assign high_d[i] = '0;
    end
  end

  always_comb begin
    if (tile_ev.emit) begin
      out_valid_d = 1'b1;
    end else if (out_stall) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tile_ev.emit) begin
      tile_q <= tile_number;
      low_q  <= low_d;
      high_q <= high_d;
    end
  end

  assign out_valid     = out_valid_q;
  assign tile_number_o = tile_q;
  assign low_a_o       = low_q[0];
  assign low_b_o       = low_q[1];
  assign low_c_o       = low_q[2];
  assign low_d_o       = low_q[3];
  assign high_a_o      = high_q[0];
  assign high_b_o      = high_q[1];
  assign high_c_o      = high_q[2];
  assign high_d_o      = high_q[3];

  // an empty output register never holds back the point stream
  a_no_stall_when_empty : assert property (
    @(posedge clk_i) disable iff (!rst_ni) !out_valid_q |-> !in_stall
  ) else $error("input stalled with empty output register");

  // a new result only follows an accepted request
  a_result_from_request : assert property (
    @(posedge clk_i) disable iff (!rst_ni) $rose(out_valid) |-> $past(accept)
  ) else $error("result appeared without a request");

  // a finish request restarts the tile numbering
  a_finish_clears_count : assert property (
    @(posedge clk_i) disable iff (!rst_ni) (accept && func_i) |=> (tile_number == '0)
  ) else $error("tile number not cleared after finish");

  // a closed tile leaves the box empty behind it, unless a point enters at once
  a_close_clears_box : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (accept && tile_ev.emit) |=> (lane_lo[0] == bbtc_pkg::CoordMax || (accept && !func_i))
  ) else $error("box not cleared after tile close");

endmodule

// ===== rtl/bbtc_lane.sv =====
// ---------------------------------------------------------------------------
// bbtc_lane
// One dimension of the bounding box: running signed minimum and maximum.
// ---------------------------------------------------------------------------
module bbtc_lane (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  bbtc_pkg::lane_ctrl_t                 ctrl_i,
  input  logic signed [bbtc_pkg::CoordW-1:0]   coord_i,
  output logic signed [bbtc_pkg::CoordW-1:0]   low_o,
  output logic signed [bbtc_pkg::CoordW-1:0]   high_o
);

  logic signed [bbtc_pkg::CoordW-1:0] min_q, min_d;
  logic signed [bbtc_pkg::CoordW-1:0] max_q, max_d;

  // box including the current point, seen by the merge stage
  always_comb begin
    low_o  = min_q;
    high_o = max_q;
    if (ctrl_i.update) begin
      if (coord_i < min_q) begin
        low_o = coord_i;
      end
      if (coord_i > max_q) begin
        high_o = coord_i;
      end
    end
  end

  always_comb begin
    if (ctrl_i.clear) begin
      min_d = bbtc_pkg::CoordMax;
      max_d = bbtc_pkg::CoordMin;
    end else begin
      min_d = low_o;
      max_d = high_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= bbtc_pkg::CoordMax;
      max_q <= bbtc_pkg::CoordMin;
    end else begin
      min_q <= min_d;
      max_q <= max_d;
    end
  end

endmodule

// ===== rtl/bbtc_ctrl.sv =====
// ---------------------------------------------------------------------------
// bbtc_ctrl
// Tile byte counter, tile close decision and tile sequence number.
// ---------------------------------------------------------------------------
module bbtc_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            accept_i,
  input  logic                            func_i,
  input  logic [bbtc_pkg::DimsW-1:0]      dims_i,
  input  logic [bbtc_pkg::LimitW-1:0]     limit_i,
  output bbtc_pkg::tile_event_t           event_o,
  output logic [bbtc_pkg::CountW-1:0]     tile_number_o
);

  logic [bbtc_pkg::BytesW-1:0] bytes_q, bytes_d, bytes_sum;
  logic [bbtc_pkg::CountW-1:0] count_q, count_d;

  // eight bytes per dimension in use
  assign bytes_sum = bytes_q + bbtc_pkg::BytesW'({dims_i, 3'b000});

  always_comb begin
    event_o.emit  = 1'b0;
    event_o.clear = 1'b0;
    if (accept_i) begin
      if (func_i) begin
        event_o.emit  = (bytes_q != '0);
        event_o.clear = 1'b1;
      end else begin
        event_o.emit  = (bytes_sum >= bbtc_pkg::BytesW'(limit_i));
        event_o.clear = event_o.emit;
      end
    end
  end

  always_comb begin
    bytes_d = bytes_q;
    count_d = count_q;
    if (accept_i) begin
      if (event_o.clear) begin
        bytes_d = '0;
      end else begin
        bytes_d = bytes_sum;
      end
      if (func_i) begin
        count_d = '0;
      end else if (event_o.emit) begin
        count_d = count_q + bbtc_pkg::CountW'(1);
      end
    end
  end

  assign tile_number_o = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_q <= '0;
      count_q <= '0;
    end else begin
      bytes_q <= bytes_d;
      count_q <= count_d;
    end
  end

endmodule

// ===== bench/bounding_box_tile_cutter_tb.sv =====
// ---------------------------------------------------------------------------
// bounding_box_tile_cutter_tb
// Drives point and finish requests through the tile cutter under random flow
// control and register settings, predicts every closed tile and its bounding
// box, and compares each tile result field by field in arrival order.
// ---------------------------------------------------------------------------
module bounding_box_tile_cutter_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic FuncPoint  = 1'b0;
  localparam logic FuncFinish = 1'b1;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 80;

  typedef struct packed {
    logic                                                func;
    logic [bbtc_pkg::CoordPorts-1:0][bbtc_pkg::CoordW-1:0] coord;
  } point_req_t;

  typedef struct packed {
    logic [bbtc_pkg::CountW-1:0]                         number;
    logic [bbtc_pkg::CoordPorts-1:0][bbtc_pkg::CoordW-1:0] low;
    logic [bbtc_pkg::CoordPorts-1:0][bbtc_pkg::CoordW-1:0] high;
  } tile_box_t;

  class tile_scoreboard;
    logic [bbtc_pkg::DimsW-1:0]         dims_reg;
    logic [bbtc_pkg::LimitW-1:0]        limit_reg;
    logic signed [bbtc_pkg::CoordW-1:0] box_lo [bbtc_pkg::MaxDims];
    logic signed [bbtc_pkg::CoordW-1:0] box_hi [bbtc_pkg::MaxDims];
    logic [bbtc_pkg::BytesW-1:0]        tile_bytes;
    logic [bbtc_pkg::CountW-1:0]        tile_count;
    tile_box_t                          expected_tiles [$];
    int unsigned                        errors;
    int unsigned                        tiles_checked;
    int unsigned                        requests_seen;
    int unsigned                        finishes_seen;
    int unsigned                        writes_seen;

    function new();
      dims_reg      = bbtc_pkg::NumDimsReset;
      limit_reg     = bbtc_pkg::TileLimitReset;
      tile_count    = '0;
      errors        = 0;
      tiles_checked = 0;
      requests_seen = 0;
      finishes_seen = 0;
      writes_seen   = 0;
      clear_box();
    endfunction

    function void clear_box();
      int i;
      for (i = 0; i < bbtc_pkg::MaxDims; i++) begin
        box_lo[i] = bbtc_pkg::CoordMax;
        box_hi[i] = bbtc_pkg::CoordMin;
      end
      tile_bytes = '0;
    endfunction

    function int unsigned lanes_in_use();
      int unsigned n;
      n = 32'(dims_reg);
      if (n == 0) begin
        n = 1;
      end else if (n > bbtc_pkg::NumLanes) begin
        n = bbtc_pkg::NumLanes;
      end
      return n;
    endfunction

    function int unsigned pending();
      return expected_tiles.size();
    endfunction

    function void write_register(logic [bbtc_pkg::CfgIdxW-1:0] idx,
                                 logic [bbtc_pkg::CfgDataW-1:0] data);
      writes_seen++;
      if (idx == bbtc_pkg::CfgNumDims) begin
        dims_reg = data[bbtc_pkg::DimsW-1:0];
      end else if (idx == bbtc_pkg::CfgTileLimit) begin
        limit_reg = data[bbtc_pkg::LimitW-1:0];
      end
    endfunction

    // lanes beyond the dimension count read zero, whatever the box holds
    function void push_tile(int unsigned lanes);
      tile_box_t t;
      int        i;
      t.number = tile_count;
      for (i = 0; i < bbtc_pkg::CoordPorts; i++) begin
        if (i < lanes && i < bbtc_pkg::MaxDims) begin
          t.low[i]  = box_lo[i];
          t.high[i] = box_hi[i];
        end else begin
          t.low[i]  = '0;
          t.high[i] = '0;
        end
      end
      expected_tiles.insert(expected_tiles.size(), t);
    endfunction

    function void note_request(point_req_t r);
      int unsigned lanes;
      int          i;
      lanes = lanes_in_use();
      requests_seen++;
      if (r.func == FuncFinish) begin
        finishes_seen++;
        if (tile_bytes != '0) begin
          push_tile(lanes);
        end
        clear_box();
        tile_count = '0;
        return;
      end
      for (i = 0; i < lanes; i++) begin
        if ($signed(r.coord[i]) < box_lo[i]) begin
          box_lo[i] = r.coord[i];
        end
        if ($signed(r.coord[i]) > box_hi[i]) begin
          box_hi[i] = r.coord[i];
        end
      end
      tile_bytes = tile_bytes + bbtc_pkg::BytesW'(8 * lanes);
      if (tile_bytes >= bbtc_pkg::BytesW'(limit_reg)) begin
        push_tile(lanes);
        tile_count = tile_count + bbtc_pkg::CountW'(1);
        clear_box();
      end
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] tile check: %s", $time, msg);
      errors++;
    endtask

    task check_tile(tile_box_t got);
      tile_box_t want;
      int        i;
      if (expected_tiles.size() == 0) begin
        report_mismatch($sformatf("tile %0d arrived with none expected", got.number));
        return;
      end
      want = expected_tiles.pop_front();
      tiles_checked++;
      if (got.number !== want.number) begin
        report_mismatch($sformatf("tile_number got %0d want %0d", got.number, want.number));
      end
      for (i = 0; i < bbtc_pkg::CoordPorts; i++) begin
        if (got.low[i] !== want.low[i]) begin
          report_mismatch($sformatf("tile %0d low_%c got %h want %h", want.number,
                                    8'h61 + i, got.low[i], want.low[i]));
        end
        if (got.high[i] !== want.high[i]) begin
          report_mismatch($sformatf("tile %0d high_%c got %h want %h", want.number,
                                    8'h61 + i, got.high[i], want.high[i]));
        end
      end
    endtask
  endclass

  logic                               clk_i = 1'b0;
  logic                               rst_ni;
  logic                               cfg_valid;
  logic                               cfg_ready;
  logic [bbtc_pkg::CfgIdxW-1:0]       cfg_index_i;
  logic [bbtc_pkg::CfgDataW-1:0]      cfg_data_i;
  logic                               in_valid;
  logic                               in_stall;
  logic                               func_i;
  logic signed [bbtc_pkg::CoordW-1:0] coord_a_i, coord_b_i, coord_c_i, coord_d_i;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic [bbtc_pkg::CountW-1:0]        tile_number_o;
  logic signed [bbtc_pkg::CoordW-1:0] low_a_o, low_b_o, low_c_o, low_d_o;
  logic signed [bbtc_pkg::CoordW-1:0] high_a_o, high_b_o, high_c_o, high_d_o;

  tile_scoreboard sb = new();

  bit          gaps_on;
  bit          stall_on;
  int unsigned hold_armed = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;

  bounding_box_tile_cutter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .func_i        (func_i),
    .coord_a_i     (coord_a_i),
    .coord_b_i     (coord_b_i),
    .coord_c_i     (coord_c_i),
    .coord_d_i     (coord_d_i),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .tile_number_o (tile_number_o),
    .low_a_o       (low_a_o),
    .low_b_o       (low_b_o),
    .low_c_o       (low_c_o),
    .low_d_o       (low_d_o),
    .high_a_o      (high_a_o),
    .high_b_o      (high_b_o),
    .high_c_o      (high_c_o),
    .high_d_o      (high_d_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("bounding_box_tile_cutter: mismatch");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off when asked for
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_armed) begin
      hold_seen <= hold_armed;
      hold_left <= HoldCycles;
      out_stall <= 1'b1;
    end else begin
      out_stall <= stall_on && ($urandom_range(99) < 18);
    end
  end

  // every handshake is observed at the rising edge
  always @(posedge clk_i) begin
    point_req_t req;
    tile_box_t  got;
    if (rst_ni) begin
      if (cfg_valid && cfg_ready) begin
        sb.write_register(cfg_index_i, cfg_data_i);
      end
      if (in_valid && !in_stall) begin
        req.func     = func_i;
        req.coord[0] = coord_a_i;
        req.coord[1] = coord_b_i;
        req.coord[2] = coord_c_i;
        req.coord[3] = coord_d_i;
        sb.note_request(req);
      end
      if (out_valid && !out_stall) begin
        got.number  = tile_number_o;
        got.low[0]  = low_a_o;
        got.low[1]  = low_b_o;
        got.low[2]  = low_c_o;
        got.low[3]  = low_d_o;
        got.high[0] = high_a_o;
        got.high[1] = high_b_o;
        got.high[2] = high_c_o;
        got.high[3] = high_d_o;
        sb.check_tile(got);
      end
    end
  end

  function automatic logic signed [bbtc_pkg::CoordW-1:0] small_coord(input int v);
    return bbtc_pkg::CoordW'(v);
  endfunction

  function automatic logic [bbtc_pkg::CoordW-1:0] random_coord();
    logic signed [bbtc_pkg::CoordW-1:0] v;
    case ($urandom_range(9))
      0:       v = bbtc_pkg::CoordMax;
      1:       v = bbtc_pkg::CoordMin;
      2, 3:    v = bbtc_pkg::CoordW'($urandom_range(200)) - bbtc_pkg::CoordW'(100);
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  function automatic logic [bbtc_pkg::LimitW-1:0] random_limit();
    case ($urandom_range(5))
      0:       return bbtc_pkg::LimitW'($urandom_range(7));
      1:       return bbtc_pkg::LimitW'(8 * $urandom_range(1, 12));
      2, 3:    return bbtc_pkg::LimitW'($urandom_range(8, 400));
      4:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic point_req_t random_request(int unsigned finish_pct);
    point_req_t r;
    int         i;
    r.func = ($urandom_range(99) < finish_pct) ? FuncFinish : FuncPoint;
    for (i = 0; i < bbtc_pkg::CoordPorts; i++) begin
      r.coord[i] = random_coord();
    end
    return r;
  endfunction

  // entered and left at a falling edge; valid stays high between requests unless a random gap drops it
  task automatic send_request(input point_req_t r);
    while (gaps_on && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid  <= 1'b1;
    func_i    <= r.func;
    coord_a_i <= r.coord[0];
    coord_b_i <= r.coord[1];
    coord_c_i <= r.coord[2];
    coord_d_i <= r.coord[3];
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
  endtask

  task automatic send_point(input logic signed [bbtc_pkg::CoordW-1:0] a, b, c, d);
    point_req_t r;
    r.func     = FuncPoint;
    r.coord[0] = a;
    r.coord[1] = b;
    r.coord[2] = c;
    r.coord[3] = d;
    send_request(r);
  endtask

  task automatic finish_stream();
    point_req_t r;
    r      = random_request(0);
    r.func = FuncFinish;
    send_request(r);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic put_register(input logic [bbtc_pkg::CfgIdxW-1:0] idx,
                              input logic [bbtc_pkg::CfgDataW-1:0] data);
    cfg_valid   <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
  endtask

  task automatic set_registers(input logic [bbtc_pkg::DimsW-1:0] dims,
                               input logic [bbtc_pkg::LimitW-1:0] limit);
    wait_idle();
    // upper data bits are random, only the low bits carry the count
    put_register(bbtc_pkg::CfgNumDims,
                 {(bbtc_pkg::CfgDataW-bbtc_pkg::DimsW)'($urandom), dims});
    put_register(bbtc_pkg::CfgTileLimit, limit);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [bbtc_pkg::DimsW-1:0] dims,
                           input logic [bbtc_pkg::LimitW-1:0] limit,
                           input int unsigned count, input int unsigned finish_pct,
                           input bit hold_off);
    set_registers(dims, limit);
    if (hold_off) begin
      hold_armed++;
    end
    repeat (count) send_request(random_request(finish_pct));
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index_i = bbtc_pkg::CfgNumDims;
    cfg_data_i  = '0;
    in_valid    = 1'b0;
    func_i      = FuncPoint;
    coord_a_i   = '0;
    coord_b_i   = '0;
    coord_c_i   = '0;
    coord_d_i   = '0;
    gaps_on     = 1'b1;
    stall_on    = 1'b1;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // two four-lane points per tile
    set_registers(3'd4, 32'd64);
    finish_stream();
    send_point(bbtc_pkg::CoordMax, bbtc_pkg::CoordMax, bbtc_pkg::CoordMax, bbtc_pkg::CoordMax);
    send_point(bbtc_pkg::CoordMin, bbtc_pkg::CoordMin, bbtc_pkg::CoordMin, bbtc_pkg::CoordMin);
    send_point(small_coord(0), small_coord(0), small_coord(0), small_coord(0));
    send_point(small_coord(-1), small_coord(-1), small_coord(-1), small_coord(-1));
    send_point(bbtc_pkg::CoordMax, bbtc_pkg::CoordMin, small_coord(1), small_coord(-1));
    finish_stream();
    finish_stream();
    send_point(small_coord(5), small_coord(-5), small_coord(7), small_coord(-7));
    send_point(small_coord(-3), small_coord(3), small_coord(-9), small_coord(9));
    // zero dimensions counts as one, a limit under eight closes every point
    set_registers(3'd0, 32'd3);
    send_point(small_coord(11), small_coord(22), small_coord(33), small_coord(44));
    send_point(bbtc_pkg::CoordMin, bbtc_pkg::CoordMax, bbtc_pkg::CoordMin, bbtc_pkg::CoordMax);
    // count above the lane number saturates
    set_registers(3'd7, 32'd0);
    send_point(small_coord(-100), small_coord(100), small_coord(-200), small_coord(200));
    send_point(bbtc_pkg::CoordMax, small_coord(1), bbtc_pkg::CoordMin, small_coord(2));
    // dimension count changed while a tile is open
    set_registers(3'd4, 32'd1000);
    send_point(small_coord(10), small_coord(20), small_coord(30), small_coord(40));
    send_point(small_coord(-10), small_coord(-20), small_coord(-30), small_coord(-40));
    set_registers(3'd2, 32'd1000);
    send_point(small_coord(50), small_coord(60), bbtc_pkg::CoordMax, bbtc_pkg::CoordMin);
    set_registers(3'd4, 32'd1000);
    send_point(small_coord(1), small_coord(2), small_coord(3), small_coord(4));
    finish_stream();
    set_registers(3'd1, 32'hFFFF_FFFF);
    send_point(bbtc_pkg::CoordMin, small_coord(0), small_coord(0), small_coord(0));
    finish_stream();

    // a stretch with no idling on either side
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    run_phase(3'd3, 32'd96, 80, 4, 1'b0);
    gaps_on  = 1'b1;
    stall_on = 1'b1;
    run_phase(3'd4, 32'hFFFF_FFFF, 60, 8, 1'b0);
    // every point closes a tile while the receiver holds off
    run_phase(3'd1, 32'd8, 50, 0, 1'b1);
    repeat (9) run_phase(3'($urandom_range(7)), random_limit(), 60, 5, 1'b0);

    wait_idle();
    $display("run covered %0d requests (%0d finishes), %0d tiles compared, %0d register writes",
             sb.requests_seen, sb.finishes_seen, sb.tiles_checked, sb.writes_seen);
    $display("dimension counts 0 to 7, tile limits 0 to all ones, one long output hold-off");
    if (sb.errors == 0) begin
      $display("bounding_box_tile_cutter: match");
    end else begin
      $display("bounding_box_tile_cutter: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/bbtc_pkg.sv
rtl/bbtc_lane.sv
rtl/bbtc_ctrl.sv
rtl/bounding_box_tile_cutter.sv
bench/bounding_box_tile_cutter_tb.sv
